/* rtl/lcg_pkg.sv */
package lcg_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SUM_W   = 2 * VALUE_W + 1;
  localparam int unsigned BIT_W   = $clog2(SUM_W);
  localparam int unsigned IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [IDX_W-1:0] REG_INCREMENT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODULUS    = 2'd2;

  localparam logic [VALUE_W-1:0] RST_MULTIPLIER = VALUE_W'(5);
  localparam logic [VALUE_W-1:0] RST_INCREMENT  = VALUE_W'(3);
  localparam logic [VALUE_W-1:0] RST_MODULUS    = VALUE_W'(23);

  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [BIT_W-1:0] SUM_MSB = BIT_W'(SUM_W - 1);

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* rtl/lcg_in_if.sv */
interface lcg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lcg_pkg::VALUE_W-1:0]   seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

/* rtl/lcg_out_if.sv */
interface lcg_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcg_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/lcg_ctrl.sv */
module lcg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  lcg_pkg::status_t  st_i,
  output lcg_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_kind_i == lcg_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (st_i.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == lcg_pkg::KIND_STEP) |=> state_q == S_MUL)
    else $error("step request did not start the multiply");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == lcg_pkg::KIND_LOAD) |=> state_q == S_IDLE)
    else $error("load request left idle");

  a_mul_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |=> state_q == S_DIV)
    else $error("multiply not followed by remainder loop");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !st_i.last) |=> state_q == S_DIV)
    else $error("remainder loop ended early");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");
`endif

endmodule

/* rtl/lcg_dp.sv */
module lcg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcg_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [lcg_pkg::VALUE_W-1:0]   cfg_data_i,
  input  logic [lcg_pkg::VALUE_W-1:0]   seed_i,
  input  lcg_pkg::cmd_t                 cmd_i,
  output lcg_pkg::status_t              st_o,
  output logic [lcg_pkg::VALUE_W-1:0]   value_o
);

  logic [lcg_pkg::VALUE_W-1:0]   mult_q, incr_q, mod_q;
  logic [lcg_pkg::VALUE_W-1:0]   cur_q;
  logic [lcg_pkg::VALUE_W-1:0]   out_q;
  logic [lcg_pkg::SUM_W-1:0]     sum_q;
  logic [lcg_pkg::VALUE_W-1:0]   rem_q, rem_d;
  logic [lcg_pkg::BIT_W-1:0]     bit_q;
  logic [2*lcg_pkg::VALUE_W-1:0] prod;
  logic [lcg_pkg::VALUE_W:0]     rem_shift;
  logic [lcg_pkg::VALUE_W:0]     rem_sub;
  logic [lcg_pkg::VALUE_W-1:0]   result;

  assign prod      = (2*lcg_pkg::VALUE_W)'(mult_q) * (2*lcg_pkg::VALUE_W)'(cur_q);
  assign rem_shift = {rem_q, sum_q[bit_q]};
  assign rem_sub   = rem_shift - {1'b0, mod_q};
  assign rem_d     = (rem_shift >= {1'b0, mod_q}) ? rem_sub[lcg_pkg::VALUE_W-1:0]
                                                   : rem_shift[lcg_pkg::VALUE_W-1:0];
  assign result    = (mod_q == '0) ? sum_q[lcg_pkg::VALUE_W-1:0] : rem_q;

  assign st_o.last = (bit_q == '0);
  assign value_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= lcg_pkg::RST_MULTIPLIER;
      incr_q <= lcg_pkg::RST_INCREMENT;
      mod_q  <= lcg_pkg::RST_MODULUS;
      cur_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lcg_pkg::REG_MULTIPLIER: mult_q <= cfg_data_i;
          lcg_pkg::REG_INCREMENT:  incr_q <= cfg_data_i;
          lcg_pkg::REG_MODULUS:    mod_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cur_q <= seed_i;
      end else if (cmd_i.fin) begin
        cur_q <= result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      sum_q <= {1'b0, prod} + lcg_pkg::SUM_W'(incr_q);
      rem_q <= '0;
      bit_q <= lcg_pkg::SUM_MSB;
    end else if (cmd_i.div) begin
      rem_q <= rem_d;
      bit_q <= bit_q - lcg_pkg::BIT_W'(1);
    end
    if (cmd_i.fin) begin
      out_q <= result;
    end
  end

endmodule

/* rtl/linear_congruential_generator.sv */
// linear congruential generator, value' = (multiplier * value + increment) mod modulus;
// a load request sets the value to its seed when it is accepted and returns nothing, a step
// request returns the new value on the result port, and the next request can be taken in
// the cycle in which that result appears: a multiply-add into a 33-bit sum, then a
// one-bit-per-cycle restoring remainder over that sum, then a write back once the previous result is taken;
// a modulus of zero yields the sum modulo 2^16; write the configuration only while idle
module linear_congruential_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lcg_in_if.sink                        req_i,
  lcg_out_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [lcg_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [lcg_pkg::VALUE_W-1:0]   cfg_data_i
);

  lcg_pkg::cmd_t    cmd;
  lcg_pkg::status_t st;

  lcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_kind_i   (req_i.kind),
    .in_ready_o  (req_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  lcg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .seed_i     (req_i.seed_value),
    .cmd_i      (cmd),
    .st_o       (st),
    .value_o    (res_o.value)
  );

endmodule
